// ===== rtl/core/npc_pkg.sv =====
// constants, types and helpers shared by the nearest palette color search
`default_nettype none
package npc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = IDX_W + 1;
  localparam int COLOR_W       = 24;
  localparam int CHAN_W        = 8;
  localparam int DIST_W        = 10;
  localparam int COUNT_W       = 9;
  localparam int SLOT_W        = 8;
  localparam int WIDE_W        = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;
  localparam int SLOT_CMP_W    = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // number of slots a query walks, clipped to the palette depth
  function automatic cnt_t sat_count(logic [COUNT_W-1:0] c);
    logic [WIDE_W-1:0] cw;
    cw = WIDE_W'(c);
    if (cw > WIDE_W'(PALETTE_DEPTH)) begin
      return CNT_W'(PALETTE_DEPTH);
    end
    return CNT_W'(cw);
  endfunction

  function automatic logic slot_in_range(logic [SLOT_W-1:0] s);
    return SLOT_CMP_W'(s) < SLOT_CMP_W'(PALETTE_DEPTH);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nearest_palette_color.sv =====
// nearest palette color search: palette store, scan sequencer and result register
//
// Input channel (in_*): a write item (kind 0) stores in_color into slot
// in_entry_index and gives no result; slots at or past the palette depth are
// ignored. A query item (kind 1) walks slots 0 to colors_in_use-1 and gives one
// result: the slot with the smallest sum of absolute channel differences,
// lowest slot on ties, 0 when no slots are in use.
// cfg_wr_en loads cfg_colors_in_use; the user must assert it only while the
// block is idle; the block itself does not enforce this. A write item is
// stored as it is taken. A query searching n slots (colors_in_use clipped to
// the palette depth) makes one palette read per cycle through the single read
// port; each entry is compared once its registered read data returns, ST_SCAN
// then sees the end of the scan and ST_DONE loads the result register. in_stall
// stays high for the whole scan and in ST_DONE, and drops as the result register
// is loaded. The result waits in an output register, so the next item is taken
// while out_stall holds it; a query that finishes while the previous result is
// still stalled waits until that result is taken.
// Reset clears the control state and colors_in_use; palette contents are
// undefined until written.
`default_nettype none
module nearest_palette_color
  import npc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_kind,
  input  wire logic [SLOT_W-1:0]    in_entry_index,
  input  wire logic [COLOR_W-1:0]   in_color,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_nearest_index,
  input  wire logic                 cfg_wr_en,
  input  wire logic [COUNT_W-1:0]   cfg_colors_in_use
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] count_cfg_r;
  cnt_t               count_r, count_nxt;
  cnt_t               rd_idx_r, rd_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  idx_t               dat_idx_r, dat_idx_nxt;
  color_t             query_r, query_nxt;
  dist_t              best_r, best_nxt;
  idx_t               best_idx_r, best_idx_nxt;
  logic               have_r, have_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_idx_r, out_idx_nxt;

  logic   in_acc;
  logic   wr_en;
  color_t rd_data;
  dist_t  distance;
  logic   issue;

  assign in_stall          = (state_r != ST_IDLE);
  assign in_acc            = in_valid && !in_stall;
  assign wr_en             = in_acc && (in_kind == KIND_WRITE) && slot_in_range(in_entry_index);
  assign issue             = (state_r == ST_SCAN) && (rd_idx_r < count_r);
  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;

  npc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (IDX_W'(in_entry_index)),
    .wdata   (in_color),
    .raddr   (rd_idx_r[IDX_W-1:0]),
    .rdata_r (rd_data)
  );

  npc_dist u_dist (
    .a        (query_r),
    .b        (rd_data),
    .distance (distance)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    dat_idx_nxt   = dat_idx_r;
    query_nxt     = query_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_QUERY)) begin
          query_nxt    = in_color;
          count_nxt    = sat_count(count_cfg_r);
          rd_idx_nxt   = '0;
          best_idx_nxt = '0;
          have_nxt     = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_vld_nxt  = 1'b1;
          dat_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + cnt_t'(1);
        end
        // compare the entry read last cycle
        if (rd_vld_r && (!have_r || (distance < best_r))) begin
          best_nxt     = distance;
          best_idx_nxt = dat_idx_r;
          have_nxt     = 1'b1;
        end
        if (!issue && !rd_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 8'(best_idx_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      count_cfg_r <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        count_cfg_r <= cfg_colors_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    rd_idx_r   <= rd_idx_nxt;
    dat_idx_r  <= dat_idx_nxt;
    query_r    <= query_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    have_r     <= have_nxt;
    out_idx_r  <= out_idx_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/npc_ram.sv =====
// generic single-write, single-read memory with registered read data
`default_nettype none
module npc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/npc_dist.sv =====
// manhattan distance between two packed rgb colors
`default_nettype none
module npc_dist
  import npc_pkg::*;
(
  input  wire color_t a,
  input  wire color_t b,
  output dist_t       distance
);

  logic [CHAN_W-1:0] d_red;
  logic [CHAN_W-1:0] d_green;
  logic [CHAN_W-1:0] d_blue;

  function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] x, logic [CHAN_W-1:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  assign d_red    = abs_diff(a[23:16], b[23:16]);
  assign d_green  = abs_diff(a[15:8],  b[15:8]);
  assign d_blue   = abs_diff(a[7:0],   b[7:0]);
  assign distance = DIST_W'(d_red) + DIST_W'(d_green) + DIST_W'(d_blue);

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for nearest_palette_color with a scoreboard that predicts each query
module testbench;
  import npc_pkg::*;

  class palette_scoreboard;
    color_t palette[PALETTE_DEPTH];
    logic [COUNT_W-1:0] colors_in_use;
    logic [7:0] nearest_q[$];
    int errors;

    function new();
      colors_in_use = '0;
      errors = 0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function int unsigned distance(color_t a, color_t b);
      int unsigned sum;
      sum = 0;
      for (int ch = 0; ch < 3; ch++) begin
        int x, y;
        x = a[ch*8 +: 8];
        y = b[ch*8 +: 8];
        sum += (x >= y) ? x - y : y - x;
      end
      return sum;
    endfunction

    function logic [7:0] nearest_slot(color_t c);
      int n, best_i;
      int unsigned best, d;
      n = (colors_in_use > PALETTE_DEPTH) ? PALETTE_DEPTH : colors_in_use;
      best = 32'hFFFF_FFFF;
      best_i = 0;
      for (int i = 0; i < n; i++) begin
        d = distance(c, palette[i]);
        if (d < best) begin
          best = d;
          best_i = i;
        end
      end
      return best_i[7:0];
    endfunction

    function void set_count(logic [COUNT_W-1:0] v);
      colors_in_use = v;
    endfunction

    function void take_item(logic kind, logic [7:0] slot, color_t c);
      if (kind == KIND_WRITE) begin
        if (slot < PALETTE_DEPTH) palette[slot] = c;
      end else begin
        nearest_q.push_back(nearest_slot(c));
      end
    endfunction

    function int pending();
      return nearest_q.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [7:0] got);
      logic [7:0] want;
      if (nearest_q.size() == 0) begin
        report_mismatch($sformatf("nearest_index %0d with no query waiting", got));
      end else begin
        want = nearest_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("nearest_index %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [SLOT_W-1:0] in_entry_index = '0;
  color_t in_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_nearest_index;
  logic cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_colors_in_use = '0;

  bit written[PALETTE_DEPTH];
  bit calm = 1'b0;
  palette_scoreboard sb;

  nearest_palette_color dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_entry_index(in_entry_index),
    .in_color(in_color),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_nearest_index(out_nearest_index),
    .cfg_wr_en(cfg_wr_en),
    .cfg_colors_in_use(cfg_colors_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 4_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_nearest_index);
  end

  function automatic logic [7:0] extreme_chan();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      default: return 8'h80;
    endcase
  endfunction

  function automatic color_t write_color();
    int r, s;
    r = $urandom_range(0, 9);
    s = $urandom_range(0, PALETTE_DEPTH - 1);
    if (r < 4) return color_t'($urandom);
    if (r < 7) return {extreme_chan(), extreme_chan(), extreme_chan()};
    // copies of written entries, some with low bits flipped, give ties and near ties
    if (written[s]) return sb.palette[s] ^ (color_t'($urandom) & 24'h010101);
    return color_t'($urandom);
  endfunction

  function automatic color_t query_color(int scan);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 || scan == 0) return color_t'($urandom);
    if (r < 65) return {extreme_chan(), extreme_chan(), extreme_chan()};
    return sb.palette[$urandom_range(0, scan - 1)] ^ (color_t'($urandom) & 24'h070707);
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] slot, input color_t c);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_kind <= 1'($urandom);
      in_entry_index <= 8'($urandom);
      in_color <= color_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_entry_index <= slot;
    in_color <= c;
    do @(posedge clk); while (in_stall);
    sb.take_item(kind, slot, c);
    if (kind == KIND_WRITE) written[slot] = 1'b1;
  endtask

  // wait until every query has answered and the block has settled
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_colors(input logic [COUNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_colors_in_use <= v;
    sb.set_count(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int plan[20] = '{1, 2, -1, 256, -1, 0, 3, 511, -1, -1, 300, 255, -1, 257, 4, -1, 128, -1,
                     5, -1};
    color_t probes[9] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                          24'h00F010, 24'h1020F0, 24'h808080, 24'h7F7F7F};
    int cnt, scan, slot;

    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty palette after reset
    send_item(KIND_QUERY, 8'hFF, 24'h000000);
    send_item(KIND_QUERY, 8'h00, 24'hFFFFFF);

    // primaries, black twice for a tie, and the top slot outside the scan
    send_item(KIND_WRITE, 8'd0, 24'h000000);
    send_item(KIND_WRITE, 8'd1, 24'hFFFFFF);
    send_item(KIND_WRITE, 8'd2, 24'hFF0000);
    send_item(KIND_WRITE, 8'd3, 24'h00FF00);
    send_item(KIND_WRITE, 8'd4, 24'h0000FF);
    send_item(KIND_WRITE, 8'd5, 24'h000000);
    send_item(KIND_WRITE, 8'hFF, 24'h000000);
    drain();
    set_colors(9'd6);
    foreach (probes[i]) send_item(KIND_QUERY, 8'($urandom), probes[i]);

    foreach (plan[p]) begin
      cnt = (plan[p] < 0) ? $urandom_range(1, 32) : plan[p];
      scan = (cnt > PALETTE_DEPTH) ? PALETTE_DEPTH : cnt;
      for (int i = 0; i < scan; i++) begin
        if (!written[i]) send_item(KIND_WRITE, 8'(i), write_color());
      end
      drain();
      calm = (p >= 8 && p <= 10);
      set_colors(9'(cnt));
      repeat (26) begin
        if ($urandom_range(0, 99) < 35) begin
          slot = (scan > 0 && $urandom_range(0, 1)) ? $urandom_range(0, scan - 1)
                                                   : $urandom_range(0, PALETTE_DEPTH - 1);
          send_item(KIND_WRITE, 8'(slot), write_color());
        end else begin
          send_item(KIND_QUERY, 8'($urandom), query_color(scan));
        end
      end
    end

    drain();
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== nearest_palette_color.f =====
rtl/core/npc_pkg.sv
rtl/core/npc_ram.sv
rtl/core/npc_dist.sv
rtl/core/nearest_palette_color.sv
test/testbench.sv
